// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the approximate pattern matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/apm_pkg.sv =====
// Package with the constants and types of the approximate pattern matcher.
`default_nettype none
package apm_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int MAX_ERRORS  = 7;
  localparam int LEVELS      = MAX_ERRORS + 1;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 7;
  localparam int ERR_W       = 3;
  localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SYM_W       = 8;
  localparam int POS_W       = 32;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEXT = 1'b1;

  localparam logic CFG_PATTERN_LENGTH = 1'b0;
  localparam logic CFG_ERROR_LIMIT    = 1'b1;

  typedef struct packed {
    logic             step;
    logic             clear;
    logic [SYM_W-1:0] symbol;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/apm_cell.sv =====
// One pattern position: its stored byte and its bit of every error-level vector.
`default_nettype none
module apm_cell
  import apm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic              load_en,
  input  wire logic              active,
  input  wire logic [LEVELS-1:0] prev_old,
  input  wire logic [LEVELS-1:0] prev_new,
  output logic      [LEVELS-1:0] old_lvl,
  output logic      [LEVELS-1:0] new_lvl,
  output logic      [LEVELS-1:0] cur_lvl
);

  logic [SYM_W-1:0]  byte_r;
  logic [LEVELS-1:0] lvl_r;
  logic [LEVELS-1:0] lvl_nxt;
  logic              miss;

  always_comb begin
    old_lvl = ctrl.clear ? '1 : lvl_r;
    miss    = !(active && (byte_r == ctrl.symbol));
    new_lvl[0] = prev_old[0] | miss;
    for (int j = 1; j < LEVELS; j++) begin
      new_lvl[j] = (prev_old[j] | miss) & prev_old[j-1] & prev_new[j-1] & old_lvl[j-1];
    end
    lvl_nxt = ctrl.step ? new_lvl : lvl_r;
  end

  assign cur_lvl = lvl_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      byte_r <= ctrl.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '1;
    end else begin
      lvl_r <= lvl_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/approximate_pattern_matcher.sv =====
// Top level of the approximate pattern matcher: cell row, position counter and output stages.
// The input channel takes load transactions (func 0) that store one pattern byte and
// text transactions (func 1) that feed one text byte. A text transaction gives exactly
// one result transaction with the match flag and the byte's position in the text; a
// load gives none. The first byte of a text clears all error-level vectors and the
// position, and a text shorter than the pattern reports no match.
// A text byte is registered at acceptance into the row of cells, which updates its
// vectors, and into the result stage; the match bit is then picked from the stored
// vectors into the output register when that register is empty or the receiver is ready.
// One transaction is accepted per cycle while in_ready is high; the cell row updates its
// vectors at each accepted text byte.
// When the receiver stalls, the output register holds and one more result waits in the
// stage before it; only then does in_ready drop.
// Reset clears all vectors to ones, the position and the short-text flag, sets the pattern
// length to one and the error limit to zero. Pattern bytes are undefined until loaded. The
// configuration port writes a register; the user must use it while idle (not enforced).
`default_nettype none
module approximate_pattern_matcher
  import apm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_func,
  input  wire logic [IDX_W-1:0] in_pattern_index,
  input  wire logic [SYM_W-1:0] in_symbol,
  input  wire logic             in_first_of_text,
  input  wire logic [POS_W-1:0] in_text_length,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_match,
  output logic      [POS_W-1:0] out_end_position,
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_index,
  input  wire logic [LEN_W-1:0] cfg_data
);

`include "assert_macros.svh"

  logic [LEN_W-1:0] pattern_length_r;
  logic [ERR_W-1:0] error_limit_r;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [POS_W-1:0] pos_use;
  logic             supp_r;
  logic             supp_nxt;

  logic             p_valid_r;
  logic [POS_W-1:0] p_pos_r;
  logic             p_supp_r;
  logic             p_move;

  logic             out_valid_r;
  logic             out_match_r;
  logic [POS_W-1:0] out_end_position_r;

  logic             accept;
  logic             text_acc;
  logic [LEN_W-1:0] m_eff;
  logic [IDX_W-1:0] m_idx;
  logic [LVL_W-1:0] e_eff;
  logic             hit;

  cell_ctrl_t              ctrl;
  logic [MAX_PATTERN-1:0]  load_vec;
  logic [MAX_PATTERN-1:0]  active_vec;
  logic [MAX_PATTERN-1:0]  sel_vec;
  logic [LEVELS-1:0]       old_a [MAX_PATTERN];
  logic [LEVELS-1:0]       new_a [MAX_PATTERN];
  logic [LEVELS-1:0]       cur_a [MAX_PATTERN];

  always_comb begin
    if (pattern_length_r == '0) begin
      m_eff = LEN_W'(1);
    end else if (pattern_length_r > LEN_W'(MAX_PATTERN)) begin
      m_eff = LEN_W'(MAX_PATTERN);
    end else begin
      m_eff = pattern_length_r;
    end
    m_idx = IDX_W'(m_eff - LEN_W'(1));
    if (error_limit_r > ERR_W'(MAX_ERRORS)) begin
      e_eff = LVL_W'(MAX_ERRORS);
    end else begin
      e_eff = LVL_W'(error_limit_r);
    end
  end

  assign p_move   = !out_valid_r || out_ready;
  assign in_ready = !p_valid_r || p_move;
  assign accept   = in_valid && in_ready;
  assign text_acc = accept && (in_func == FUNC_TEXT);

  always_comb begin
    ctrl.step   = text_acc;
    ctrl.clear  = in_first_of_text;
    ctrl.symbol = in_symbol;
    load_vec    = '0;
    if (accept && (in_func == FUNC_LOAD)) begin
      load_vec = MAX_PATTERN'(1) << in_pattern_index;
    end
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [LEVELS-1:0] prev_old;
    logic [LEVELS-1:0] prev_new;

    if (k == 0) begin : g_head
      assign prev_old = '0;
      assign prev_new = '0;
    end else begin : g_link
      assign prev_old = old_a[k-1];
      assign prev_new = new_a[k-1];
    end

    assign active_vec[k] = LEN_W'(k) < m_eff;
    assign sel_vec[k]    = cur_a[k][e_eff];

    apm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .load_en  (load_vec[k]),
      .active   (active_vec[k]),
      .prev_old (prev_old),
      .prev_new (prev_new),
      .old_lvl  (old_a[k]),
      .new_lvl  (new_a[k]),
      .cur_lvl  (cur_a[k])
    );
  end

  assign hit = !sel_vec[m_idx];

  always_comb begin
    pos_use  = in_first_of_text ? '0 : pos_r;
    pos_nxt  = (pos_use == '1) ? pos_use : pos_use + POS_W'(1);
    supp_nxt = in_first_of_text ? (in_text_length < POS_W'(m_eff)) : supp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= LEN_W'(1);
      error_limit_r    <= '0;
      pos_r            <= '0;
      supp_r           <= 1'b0;
      p_valid_r        <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PATTERN_LENGTH: pattern_length_r <= cfg_data;
          CFG_ERROR_LIMIT:    error_limit_r    <= cfg_data[ERR_W-1:0];
          default:            pattern_length_r <= pattern_length_r;
        endcase
      end
      if (text_acc) begin
        pos_r  <= pos_nxt;
        supp_r <= supp_nxt;
      end
      if (text_acc) begin
        p_valid_r <= 1'b1;
      end else if (p_move) begin
        p_valid_r <= 1'b0;
      end
      if (p_move) begin
        out_valid_r <= p_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_acc) begin
      p_pos_r  <= pos_use;
      p_supp_r <= supp_nxt;
    end
    if (p_move && p_valid_r) begin
      out_match_r        <= hit && !p_supp_r;
      out_end_position_r <= p_pos_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_match        = out_match_r;
  assign out_end_position = out_end_position_r;

  `ASSERT_SAME(a_no_step_when_blocked, clk, rst_n, p_valid_r && !p_move, !in_ready,
    "input accepted while the result stage is blocked")
  `ASSERT_NEXT(a_text_gives_result, clk, rst_n, text_acc, p_valid_r,
    "accepted text byte did not enter the result stage")
  `ASSERT_NEXT(a_short_text_suppressed, clk, rst_n,
    text_acc && in_first_of_text && (in_text_length < POS_W'(m_eff)), p_supp_r,
    "short text not marked for suppression")

endmodule
`default_nettype wire
